// ----- src/rlc_pkg.sv -----
// Package for the radius leader clustering block: transfer payload types,
// operation and register codes, fixed constants. No dependencies.
`default_nettype none
package rlc_pkg;

    localparam int MAX_CLUSTERS_DEF  = 512;
    localparam int MAX_SOLUTIONS_DEF = 512;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] CFG_RADIUS   = 2'd0;
    localparam logic [1:0] CFG_MIN_SIZE = 2'd1;
    localparam logic [1:0] CFG_OCC_CAP  = 2'd2;

    localparam logic [14:0] RADIUS_RST   = 15'd819;
    localparam logic [9:0]  MIN_SIZE_RST = 10'd2;
    localparam logic [8:0]  OCC_CAP_RST  = 9'd500;

    // node / 100 as (node * GRP_RECIP) >> GRP_SHIFT, exact for 11-bit nodes
    localparam logic [12:0] GRP_RECIP   = 13'd5243;
    localparam int          GRP_SHIFT   = 19;
    localparam logic [6:0]  NODES_PER_GROUP = 7'd100;
    localparam logic [23:0] GROUP_SCALE = 24'd10000000;
    localparam logic [13:0] PIXEL_SCALE = 14'd10000;
    localparam logic [9:0]  SIZE_SAT    = 10'd1023;

    typedef struct packed {
        logic [1:0]         operation;
        logic [10:0]        node_index;
        logic [15:0]        detector_id;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [15:0]        arrival_time;
    } t_in;

    typedef struct packed {
        logic               entry_valid;
        logic               is_last;
        logic [27:0]        path_id;
        logic [15:0]        entry_detector;
        logic signed [15:0] out_dir_x;
        logic signed [15:0] out_dir_y;
        logic signed [15:0] out_dir_z;
        logic [15:0]        out_time;
        logic [9:0]         cluster_size;
        logic [15:0]        node_size;
        logic               overflow_seen;
    } t_out;

    typedef struct packed {
        logic clr;
        logic vld;
    } t_scan_ctl;

    typedef struct packed {
        logic found;
        logic busy;
    } t_scan_stat;

endpackage
`default_nettype wire

// ----- src/rlc_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module rlc_ram #(
    parameter int W = 32,
    parameter int D = 512
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/rlc_dist.sv -----
// Nearest-centre tracker: squared x-y distance, registered products, then
// strict-less best update (earliest wins). Depends on rlc_pkg.
`default_nettype none
module rlc_dist
    import rlc_pkg::*;
#(
    parameter int IDX_W = 9
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_scan_ctl          i_ctl,
    input  wire logic [IDX_W-1:0]   i_idx,
    input  wire logic signed [15:0] i_cx,
    input  wire logic signed [15:0] i_cy,
    input  wire logic signed [15:0] i_sx,
    input  wire logic signed [15:0] i_sy,
    output t_scan_stat              o_stat,
    output logic [33:0]             o_best_d,
    output logic [IDX_W-1:0]        o_best_idx
);
    logic signed [16:0] dx, dy;
    logic signed [33:0] px, py;
    logic [32:0]        r_sqx, r_sqy;
    logic [IDX_W-1:0]   r_idx1;
    logic               r_v1, r_found;
    logic [33:0]        sum;

    assign dx  = {i_cx[15], i_cx} - {i_sx[15], i_sx};
    assign dy  = {i_cy[15], i_cy} - {i_sy[15], i_sy};
    assign px  = dx * dx;
    assign py  = dy * dy;
    assign sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_found <= 1'b0;
        end else if (i_ctl.clr) begin
            r_v1    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_v1 <= i_ctl.vld;
            if (r_v1 && (!r_found || sum < o_best_d)) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sqx  <= px[32:0];
        r_sqy  <= py[32:0];
        r_idx1 <= i_idx;
        if (r_v1 && (!r_found || sum < o_best_d)) begin
            o_best_d   <= sum;
            o_best_idx <= r_idx1;
        end
    end

    assign o_stat.found = r_found;
    assign o_stat.busy  = r_v1;
endmodule
`default_nettype wire

// ----- src/radius_leader_clustering.sv -----
// Top level: command FSM, cluster and solution memories, fetch walker.
// Depends on rlc_pkg, rlc_ram, rlc_dist.
//
// Channel  | Signals                          | Transfer
// ---------+----------------------------------+-------------------------------
// command  | i_start, o_busy, i_item          | i_start high while o_busy low
// result   | o_res_vld, o_res                 | one cycle per strobe, no stall
// config   | i_cfg_we, i_cfg_idx, i_cfg_data  | i_cfg_we high
//
// Add: centres are read one per cycle across all clusters, then the scan
// drains before the decision; a join adds a read-modify-write of the best
// cluster and a solution list link; a skipped add never raises o_busy.
// Fetch: the walker visits clusters and follows list links; the result
// strobe follows in the first idle cycle.
// Reset clears counters and control only; memories hold no reset state.
// Results cannot be stalled; o_busy is low only when idle.
`default_nettype none
module radius_leader_clustering
    import rlc_pkg::*;
#(
    parameter int MAX_CLUSTERS  = MAX_CLUSTERS_DEF,
    parameter int MAX_SOLUTIONS = MAX_SOLUTIONS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire t_in         i_item,
    output logic             o_res_vld,
    output t_out             o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [14:0] i_cfg_data
);
    localparam int CA  = $clog2(MAX_CLUSTERS);
    localparam int CCW = $clog2(MAX_CLUSTERS + 1);
    localparam int SA  = $clog2(MAX_SOLUTIONS);
    localparam int SCW = $clog2(MAX_SOLUTIONS + 1);
    localparam int CW  = 32 + 2 * SA + SCW;
    localparam int SW  = 64 + SA;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_BEGIN  = 13'b0000000000010,
        S_ASCAN  = 13'b0000000000100,
        S_ADRAIN = 13'b0000000001000,
        S_ADEC   = 13'b0000000010000,
        S_AJRD   = 13'b0000000100000,
        S_AJUPD  = 13'b0000001000000,
        S_AJLINK = 13'b0000010000000,
        S_FRD    = 13'b0000100000000,
        S_FEV    = 13'b0001000000000,
        S_WALK   = 13'b0010000000000,
        S_WNX    = 13'b0100000000000,
        S_FOUT   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    logic [14:0] r_radius;
    logic [9:0]  r_min;
    logic [8:0]  r_cap;
    logic [29:0] r_r2;

    logic [10:0] r_node;
    logic [15:0] r_det;
    logic [15:0] r_offered;
    logic [9:0]  r_occ;
    logic [CCW-1:0] r_ctotal;
    logic [SCW-1:0] r_stored;
    logic [SCW-1:0] r_cursor;
    logic        r_ovf;
    logic [1:0]  r_bcnt;

    logic [4:0]  r_grp;
    logic [27:0] r_gterm;
    logic [6:0]  r_pix;
    logic [27:0] r_base;
    logic [23:0] grp_prod;

    logic signed [15:0] r_x, r_y, r_z;
    logic [15:0] r_t;
    logic [CCW-1:0] r_sidx;
    logic        r_rd_vld;
    logic [CA-1:0] r_rd_idx;
    logic [CA-1:0] r_best;
    logic [SA-1:0] r_snew, r_otail;

    logic [CCW-1:0] r_fci;
    logic [SCW-1:0] r_seen, r_k, r_fm;
    logic        r_phase, r_last;
    logic [CA-1:0] r_fcl;
    logic [SA-1:0] r_s;

    logic        r_ovld;
    t_out        r_out, n_out;

    logic          cl_we;
    logic [CA-1:0] cl_waddr, cl_raddr;
    logic [CW-1:0] cl_wdata, cl_rdata;
    logic          sl_we;
    logic [SA-1:0] sl_waddr, sl_raddr;
    logic [SW-1:0] sl_wdata, sl_rdata;

    logic signed [15:0] cl_cx, cl_cy;
    logic [SA-1:0]  cl_head, cl_tail;
    logic [SCW-1:0] cl_m;
    logic [SA-1:0]  sl_next;
    logic [63:0]    sl_pay;

    t_scan_ctl  sctl;
    t_scan_stat sstat;
    logic [33:0]   best_d;
    logic [CA-1:0] best_idx;

    logic acc, add_skip, add_join, add_ovf;
    logic fev_ok, fev_hit, fev_more;
    logic [SCW-1:0] fev_rem;
    logic [15:0] size_ext;

    assign cl_cx   = cl_rdata[CW-1 -: 16];
    assign cl_cy   = cl_rdata[CW-17 -: 16];
    assign cl_head = cl_rdata[2*SA+SCW-1 -: SA];
    assign cl_tail = cl_rdata[SA+SCW-1 -: SA];
    assign cl_m    = cl_rdata[SCW-1:0];
    assign sl_next = sl_rdata[SA-1:0];
    assign sl_pay  = sl_rdata[SW-1:SA];

    assign acc      = i_start && (r_state == S_IDLE);
    assign add_skip = ({1'b0, r_occ} > {2'b00, r_cap}) ||
                      (!i_item.dir_x[15] && (i_item.dir_x != 16'sd0)) ||
                      (!i_item.dir_z[15] && (i_item.dir_z != 16'sd0));
    assign add_join = sstat.found && (best_d < {4'd0, r_r2});
    assign add_ovf  = (r_stored == SCW'(MAX_SOLUTIONS)) ||
                      (!add_join && (r_ctotal == CCW'(MAX_CLUSTERS)));

    assign fev_rem  = r_cursor - r_seen;
    assign fev_ok   = 32'(cl_m) >= 32'(r_min);
    assign fev_hit  = fev_rem < cl_m;
    assign fev_more = ({1'b0, fev_rem} + (SCW+1)'(1)) < {1'b0, cl_m};
    assign size_ext = 16'(r_fm);
    assign grp_prod = 24'(r_node) * 24'(GRP_RECIP);

    assign sctl.clr = acc && (i_item.operation == OP_ADD);
    assign sctl.vld = r_rd_vld;

    rlc_ram #(.W(CW), .D(MAX_CLUSTERS)) u_cl_ram (
        .i_clk(i_clk), .i_we(cl_we), .i_waddr(cl_waddr), .i_wdata(cl_wdata),
        .i_raddr(cl_raddr), .o_rdata(cl_rdata)
    );

    rlc_ram #(.W(SW), .D(MAX_SOLUTIONS)) u_sl_ram (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(sl_waddr), .i_wdata(sl_wdata),
        .i_raddr(sl_raddr), .o_rdata(sl_rdata)
    );

    rlc_dist #(.IDX_W(CA)) u_dist (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(sctl), .i_idx(r_rd_idx),
        .i_cx(cl_cx), .i_cy(cl_cy), .i_sx(r_x), .i_sy(r_y),
        .o_stat(sstat), .o_best_d(best_d), .o_best_idx(best_idx)
    );

    // memory port control
    always_comb begin
        cl_we    = 1'b0;
        cl_waddr = r_ctotal[CA-1:0];
        cl_wdata = {r_x, r_y, r_stored[SA-1:0], r_stored[SA-1:0], SCW'(1)};
        cl_raddr = r_fci[CA-1:0];
        sl_we    = 1'b0;
        sl_waddr = r_stored[SA-1:0];
        sl_wdata = {r_x, r_y, r_z, r_t, SA'(0)};
        sl_raddr = r_s;
        unique case (r_state)
            S_ASCAN: begin
                cl_raddr = r_sidx[CA-1:0];
            end
            S_ADEC: begin
                if (!add_ovf) begin
                    sl_we = 1'b1;
                    cl_we = !add_join;
                end
            end
            S_AJRD: begin
                cl_raddr = r_best;
            end
            S_AJUPD: begin
                cl_we    = 1'b1;
                cl_waddr = r_best;
                cl_wdata = {cl_cx, cl_cy, cl_head, r_snew, cl_m + SCW'(1)};
                sl_raddr = cl_tail;
            end
            S_AJLINK: begin
                sl_we    = 1'b1;
                sl_waddr = r_otail;
                sl_wdata = {sl_pay, r_snew};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (i_item.operation)
                        OP_BEGIN: n_state = S_BEGIN;
                        OP_ADD:   n_state = add_skip ? S_IDLE : S_ASCAN;
                        OP_FETCH: n_state = S_FRD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_BEGIN:  n_state = (r_bcnt == 2'd2) ? S_IDLE : S_BEGIN;
            S_ASCAN:  n_state = (r_sidx == r_ctotal) ? S_ADRAIN : S_ASCAN;
            S_ADRAIN: n_state = (!r_rd_vld && !sstat.busy) ? S_ADEC : S_ADRAIN;
            S_ADEC:   n_state = (!add_ovf && add_join) ? S_AJRD : S_IDLE;
            S_AJRD:   n_state = S_AJUPD;
            S_AJUPD:  n_state = S_AJLINK;
            S_AJLINK: n_state = S_IDLE;
            S_FRD: begin
                if (r_fci == r_ctotal) begin
                    n_state = r_phase ? S_WALK : S_IDLE;
                end else begin
                    n_state = S_FEV;
                end
            end
            S_FEV: begin
                if ((!r_phase && fev_ok && fev_hit && fev_more) || (r_phase && fev_ok)) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_WALK:   n_state = (r_k == '0) ? S_FOUT : S_WNX;
            S_WNX:    n_state = S_WALK;
            S_FOUT:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // result word
    always_comb begin
        n_out = r_out;
        unique case (r_state)
            S_FRD: begin
                n_out                = '0;
                n_out.entry_detector = r_det;
                n_out.node_size      = r_offered;
                n_out.overflow_seen  = r_ovf;
            end
            S_FOUT: begin
                n_out.entry_valid  = 1'b1;
                n_out.is_last      = r_last;
                n_out.path_id      = r_base + 28'(r_fcl) + 28'd1;
                n_out.out_dir_x    = sl_pay[63:48];
                n_out.out_dir_y    = sl_pay[47:32];
                n_out.out_dir_z    = sl_pay[31:16];
                n_out.out_time     = sl_pay[15:0];
                n_out.cluster_size = (size_ext > 16'(SIZE_SAT)) ? SIZE_SAT : size_ext[9:0];
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_radius  <= RADIUS_RST;
            r_min     <= MIN_SIZE_RST;
            r_cap     <= OCC_CAP_RST;
            r_node    <= '0;
            r_det     <= '0;
            r_offered <= '0;
            r_occ     <= '0;
            r_ctotal  <= '0;
            r_stored  <= '0;
            r_cursor  <= '0;
            r_ovf     <= 1'b0;
            r_bcnt    <= '0;
            r_rd_vld  <= 1'b0;
            r_ovld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_ASCAN) && (r_sidx != r_ctotal);
            r_ovld   <= (r_state == S_FOUT) ||
                        ((r_state == S_FRD) && (r_fci == r_ctotal) && !r_phase);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RADIUS:   r_radius <= i_cfg_data;
                    CFG_MIN_SIZE: r_min    <= i_cfg_data[9:0];
                    CFG_OCC_CAP:  r_cap    <= i_cfg_data[8:0];
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc && i_item.operation == OP_BEGIN) begin
                        r_node    <= i_item.node_index;
                        r_det     <= i_item.detector_id;
                        r_offered <= '0;
                        r_occ     <= '0;
                        r_ctotal  <= '0;
                        r_stored  <= '0;
                        r_cursor  <= '0;
                        r_ovf     <= 1'b0;
                        r_bcnt    <= '0;
                    end else if (acc && i_item.operation == OP_ADD) begin
                        if (r_offered != 16'hFFFF) begin
                            r_offered <= r_offered + 16'd1;
                        end
                        if ({1'b0, r_occ} <= {2'b00, r_cap}) begin
                            r_occ <= r_occ + 10'd1;
                        end
                    end
                end
                S_BEGIN: r_bcnt <= r_bcnt + 2'd1;
                S_ADEC: begin
                    if (add_ovf) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_stored <= r_stored + SCW'(1);
                        if (!add_join) begin
                            r_ctotal <= r_ctotal + CCW'(1);
                        end
                    end
                end
                S_FOUT: begin
                    r_cursor <= r_cursor + SCW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_r2    <= 30'(r_radius) * 30'(r_radius);
        r_grp   <= grp_prod[GRP_SHIFT +: 5];
        r_gterm <= 28'(r_grp) * 28'(GROUP_SCALE);
        r_pix   <= 7'(r_node - 11'(r_grp) * 11'(NODES_PER_GROUP));
        r_base  <= r_gterm + 28'(r_pix) * 28'(PIXEL_SCALE);
        r_out   <= n_out;
        unique case (r_state)
            S_IDLE: begin
                r_x    <= i_item.dir_x;
                r_y    <= i_item.dir_y;
                r_z    <= i_item.dir_z;
                r_t    <= i_item.arrival_time;
                r_sidx <= '0;
                r_fci  <= '0;
                r_seen <= '0;
                r_phase <= 1'b0;
            end
            S_ASCAN: begin
                r_rd_idx <= r_sidx[CA-1:0];
                if (r_sidx != r_ctotal) begin
                    r_sidx <= r_sidx + CCW'(1);
                end
            end
            S_ADEC: begin
                r_snew <= r_stored[SA-1:0];
                r_best <= best_idx;
            end
            S_AJUPD: r_otail <= cl_tail;
            S_FRD: begin
                r_last <= 1'b1;
            end
            S_FEV: begin
                if (!r_phase) begin
                    if (fev_ok && fev_hit) begin
                        r_fcl <= r_fci[CA-1:0];
                        r_fm  <= cl_m;
                        r_k   <= fev_rem;
                        r_s   <= cl_head;
                        if (fev_more) begin
                            r_last <= 1'b0;
                        end else begin
                            r_phase <= 1'b1;
                            r_fci   <= r_fci + CCW'(1);
                        end
                    end else begin
                        if (fev_ok) begin
                            r_seen <= r_seen + cl_m;
                        end
                        r_fci <= r_fci + CCW'(1);
                    end
                end else if (fev_ok) begin
                    r_last <= 1'b0;
                end else begin
                    r_fci <= r_fci + CCW'(1);
                end
            end
            S_WNX: begin
                r_s <= sl_next;
                r_k <= r_k - SCW'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_res_vld = r_ovld;
    assign o_res     = r_out;

    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= SCW'(MAX_SOLUTIONS))
        else $error("solution count beyond store depth");

    a_cl_le_sol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ctotal) <= 32'(r_stored))
        else $error("more clusters than stored solutions");

    a_cursor_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_res.entry_valid) |-> (r_cursor == $past(r_cursor) + SCW'(1)))
        else $error("emitted entry without cursor advance");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_item.operation == OP_BEGIN ||
         i_item.operation == OP_FETCH)) |=> o_busy)
        else $error("begin or fetch not taken up");
endmodule
`default_nettype wire
